>>> hw/rtl/rtbf_pkg.sv
// ----------------------------------------------------------------------------
// rtbf_pkg
// Shared types and constants for the 24-pin band formatter.
// ----------------------------------------------------------------------------
package rtbf_pkg;

  localparam int unsigned BANKS      = 24;
  localparam int unsigned STORE_ROWS = 512;
  localparam int unsigned ROW_W      = 9;

  localparam logic [1:0] REQ_RASTER = 2'd0;
  localparam logic [1:0] REQ_FF     = 2'd1;
  localparam logic [1:0] REQ_PULL   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NOTHING = 2'd2;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_S_ESC  = 4'd1;
  localparam logic [3:0] PH_S_3    = 4'd2;
  localparam logic [3:0] PH_S_N    = 4'd3;
  localparam logic [3:0] PH_S_CR   = 4'd4;
  localparam logic [3:0] PH_S_LF   = 4'd5;
  localparam logic [3:0] PH_G_ESC  = 4'd6;
  localparam logic [3:0] PH_G_STAR = 4'd7;
  localparam logic [3:0] PH_G_MODE = 4'd8;
  localparam logic [3:0] PH_G_NL   = 4'd9;
  localparam logic [3:0] PH_G_NH   = 4'd10;
  localparam logic [3:0] PH_G_DATA = 4'd11;
  localparam logic [3:0] PH_FF     = 4'd12;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_MODE = 8'h27;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] SKIP_CHUNK = 8'd255;
  localparam logic [4:0] LAST_LINE  = 5'd23;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       end_of_burst;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    result_t          res;
    logic             mem_wr;
    logic             mem_rd;
    logic             use_store;
    logic             zero;
    logic [4:0]       bank;
    logic [ROW_W-1:0] row;
    logic [2:0]       col_lo;
    logic [1:0]       sub;
    logic [7:0]       px;
  } job_t;

endpackage

>>> hw/rtl/rtbf_ram.sv
// ----------------------------------------------------------------------------
// rtbf_ram
// Generic simple dual-port RAM, registered read, read-first.
// ----------------------------------------------------------------------------
module rtbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rtbf_fifo.sv
// ----------------------------------------------------------------------------
// rtbf_fifo
// Small register FIFO for words of WIDTH bits.
// ----------------------------------------------------------------------------
module rtbf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/rtbf_front.sv
// ----------------------------------------------------------------------------
// rtbf_front
// Request decode, band/line tracking and output stream sequencer.
// ----------------------------------------------------------------------------
module rtbf_front import rtbf_pkg::*; #(
  parameter int unsigned LINE_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] pixel_byte_i,
  input  logic       last_in_line_i,
  output job_t       job_o
);

  logic [4:0]  bl_q, bl_d;
  logic [9:0]  bil_q, bil_d;
  logic [13:0] ue_q, ue_d;
  logic [15:0] blank_q, blank_d;
  logic [3:0]  phase_q, phase_d;
  logic [20:0] skip_q, skip_d;
  logic        ffp_q, ffp_d;
  logic        post_q, post_d;
  logic [12:0] col_q, col_d;
  logic [1:0]  sub_q, sub_d;
  logic [12:0] cc_q, cc_d;
  logic [28:0] prod;

  assign prod = 29'(ue_q) * 29'd21846;
  assign cc_d = prod[28:16] + 13'd1;

  always_comb begin
    logic        busy, flush, ff;
    logic [13:0] ue_n, off1;
    logic [2:0]  jmax;
    busy    = (phase_q != PH_IDLE);
    flush   = 1'b0;
    ff      = 1'b0;
    ue_n    = ue_q;
    off1    = '0;
    jmax    = '0;
    bl_d    = bl_q;
    bil_d   = bil_q;
    ue_d    = ue_q;
    blank_d = blank_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    ffp_d   = ffp_q;
    post_d  = post_q;
    col_d   = col_q;
    sub_d   = sub_q;
    job_o   = '0;
    for (int j = 0; j < 8; j++) begin
      if (pixel_byte_i[7-j]) begin
        jmax = 3'(j);
      end
    end
    if (accept_i) begin
      priority if (req_type_i == REQ_PULL) begin
        if (!busy) begin
          job_o.res.status = ST_NOTHING;
        end else begin
          job_o.res.out_valid = 1'b1;
          unique case (phase_q)
            PH_S_ESC: begin
              job_o.res.out_byte = CH_ESC;
              phase_d = PH_S_3;
            end
            PH_S_3: begin
              job_o.res.out_byte = CH_3;
              phase_d = PH_S_N;
            end
            PH_S_N: begin
              if (skip_q < 21'(SKIP_CHUNK)) begin
                job_o.res.out_byte = skip_q[7:0];
                skip_d = '0;
              end else begin
                job_o.res.out_byte = SKIP_CHUNK;
                skip_d = skip_q - 21'(SKIP_CHUNK);
              end
              phase_d = PH_S_CR;
            end
            PH_S_CR: begin
              job_o.res.out_byte = CH_CR;
              phase_d = PH_S_LF;
            end
            PH_S_LF: begin
              job_o.res.out_byte = CH_LF;
              if (skip_q != '0) begin
                phase_d = PH_S_ESC;
              end else if (post_q) begin
                post_d = 1'b0;
                if (ffp_q) begin
                  phase_d = PH_FF;
                end else begin
                  phase_d = PH_IDLE;
                  job_o.res.end_of_burst = 1'b1;
                end
              end else begin
                phase_d = PH_G_ESC;
              end
            end
            PH_G_ESC: begin
              job_o.res.out_byte = CH_ESC;
              phase_d = PH_G_STAR;
            end
            PH_G_STAR: begin
              job_o.res.out_byte = CH_STAR;
              phase_d = PH_G_MODE;
            end
            PH_G_MODE: begin
              job_o.res.out_byte = CH_MODE;
              phase_d = PH_G_NL;
            end
            PH_G_NL: begin
              job_o.res.out_byte = cc_q[7:0];
              phase_d = PH_G_NH;
            end
            PH_G_NH: begin
              job_o.res.out_byte = {3'b000, cc_q[12:8]};
              col_d   = '0;
              sub_d   = '0;
              phase_d = PH_G_DATA;
            end
            PH_G_DATA: begin
              job_o.use_store = 1'b1;
              job_o.zero      = col_q[12];
              job_o.row       = col_q[11:3];
              job_o.col_lo    = col_q[2:0];
              job_o.sub       = sub_q;
              job_o.mem_rd    = !col_q[12] && (col_q[2:0] == 3'd0) && (sub_q == 2'd0);
              if ((col_q == cc_q - 13'd1) && (sub_q == 2'd2)) begin
                ue_d    = '0;
                skip_d  = 21'd24;
                post_d  = 1'b1;
                phase_d = PH_S_ESC;
              end else if (sub_q == 2'd2) begin
                sub_d = '0;
                col_d = col_q + 13'd1;
              end else begin
                sub_d = sub_q + 2'd1;
              end
            end
            PH_FF: begin
              job_o.res.out_byte     = CH_FF;
              job_o.res.end_of_burst = 1'b1;
              ffp_d   = 1'b0;
              post_d  = 1'b0;
              phase_d = PH_IDLE;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end else if (req_type_i != REQ_RASTER && req_type_i != REQ_FF) begin
        job_o.res.status = ST_NOTHING;
      end else if (busy) begin
        job_o.res.status = ST_REFUSED;
      end else if (req_type_i == REQ_RASTER) begin
        if (32'(bil_q) < LINE_BYTES && 32'(bil_q) < STORE_ROWS && pixel_byte_i != '0) begin
          job_o.mem_wr = 1'b1;
          job_o.bank   = bl_q;
          job_o.row    = bil_q[ROW_W-1:0];
          job_o.px     = pixel_byte_i;
          off1 = 14'({bil_q[8:0], 4'b0000}) + 14'({bil_q[8:0], 3'b000})
               + 14'(jmax) * 14'd3 + 14'(bl_q[4:3]) + 14'd1;
          if (off1 > ue_q) begin
            ue_n = off1;
          end
        end
        ue_d = ue_n;
        if (last_in_line_i) begin
          bil_d = '0;
          if (bl_q == LAST_LINE) begin
            bl_d  = '0;
            flush = 1'b1;
          end else begin
            bl_d = bl_q + 5'd1;
          end
        end else if (bil_q != 10'h3FF) begin
          bil_d = bil_q + 10'd1;
        end
      end else begin
        ff    = 1'b1;
        flush = (bl_q != '0);
      end
    end
    if (flush) begin
      if (ue_n == '0) begin
        if (blank_q != 16'hFFFF) begin
          blank_d = blank_q + 16'd1;
        end
      end else begin
        post_d = 1'b0;
        if (blank_q != '0) begin
          skip_d  = 21'({blank_q, 4'b0000}) + 21'({blank_q, 3'b000});
          blank_d = '0;
          phase_d = PH_S_ESC;
        end else begin
          phase_d = PH_G_ESC;
        end
      end
    end
    if (ff) begin
      bl_d    = '0;
      bil_d   = '0;
      blank_d = '0;
      if (flush && ue_n != '0) begin
        ffp_d = 1'b1;
      end else begin
        phase_d = PH_FF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_q    <= '0;
      bil_q   <= '0;
      ue_q    <= '0;
      blank_q <= '0;
      phase_q <= PH_IDLE;
      skip_q  <= '0;
      ffp_q   <= 1'b0;
      post_q  <= 1'b0;
      col_q   <= '0;
      sub_q   <= '0;
      cc_q    <= 13'd1;
    end else begin
      bl_q    <= bl_d;
      bil_q   <= bil_d;
      ue_q    <= ue_d;
      blank_q <= blank_d;
      phase_q <= phase_d;
      skip_q  <= skip_d;
      ffp_q   <= ffp_d;
      post_q  <= post_d;
      col_q   <= col_d;
      sub_q   <= sub_d;
      cc_q    <= cc_d;
    end
  end

  a_ffp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ffp_q |-> phase_q != PH_IDLE) else $error("form feed pending while idle");
  a_idle_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !post_q) else $error("post-data flag left set");
  a_data_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_G_DATA |-> ue_q != '0) else $error("data phase with empty band");

endmodule

>>> hw/rtl/rtbf_back.sv
// ----------------------------------------------------------------------------
// rtbf_back
// Column store access, row buffer, byte assembly and result queue.
// ----------------------------------------------------------------------------
module rtbf_back import rtbf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    job_i,
  input  logic    job_valid_i,
  output logic    job_take_o,
  output logic    clearing_o,
  input  logic    res_pop_i,
  output result_t res_o,
  output logic    res_empty_o
);

  logic                          clr_q;
  logic [ROW_W-1:0]              clr_row_q;
  logic                          b_valid_q;
  job_t                          b_job_q;
  logic [BANKS-1:0][7:0]         rdata, src, buf_q;
  logic                          b_fire, ofifo_full, rd_en;
  logic [ROW_W-1:0]              waddr;
  logic [7:0]                    formed;
  result_t                       res_d, res_head;

  assign clearing_o = clr_q;
  assign b_fire     = b_valid_q && !ofifo_full;
  assign job_take_o = job_valid_i && !clr_q && (!b_valid_q || b_fire);
  assign rd_en      = job_take_o && (job_i.mem_rd || job_i.mem_wr);
  assign waddr      = clr_q ? clr_row_q : b_job_q.row;

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    logic       we;
    logic [7:0] wd;
    assign we = clr_q || (b_fire && b_job_q.mem_rd)
             || (b_fire && b_job_q.mem_wr && b_job_q.bank == 5'(k));
    assign wd = (!clr_q && b_job_q.mem_wr) ? (rdata[k] | b_job_q.px) : 8'h00;
    rtbf_ram #(.WIDTH(8), .DEPTH(STORE_ROWS)) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wd),
      .re_i    (rd_en),
      .raddr_i (job_i.row),
      .rdata_o (rdata[k])
    );
  end

  assign src = b_job_q.mem_rd ? rdata : buf_q;

  always_comb begin
    logic [4:0] bidx;
    formed = '0;
    for (int i = 0; i < 8; i++) begin
      bidx = {b_job_q.sub, 3'b000} + 5'(i);
      if (bidx < 5'(BANKS)) begin
        formed[7-i] = src[bidx][3'd7 - b_job_q.col_lo];
      end
    end
    res_d = b_job_q.res;
    if (b_job_q.use_store) begin
      res_d.out_byte = b_job_q.zero ? 8'h00 : formed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      b_job_q <= job_i;
    end
    if (b_fire && b_job_q.mem_rd) begin
      buf_q <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_row_q <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_row_q <= clr_row_q + 1'b1;
        if (clr_row_q == ROW_W'(STORE_ROWS - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (job_take_o) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  rtbf_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_fire),
    .data_i  (res_d),
    .full_o  (ofifo_full),
    .pop_i   (res_pop_i),
    .data_o  (res_head),
    .empty_o (res_empty_o)
  );

  assign res_o = res_head;

  a_clr_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !b_valid_q) else $error("store access during clearing pass");
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> !(b_job_q.mem_rd && b_job_q.mem_wr)) else $error("read and write in one word");

endmodule

>>> hw/rtl/raster_to_24pin_band_formatter.sv
// ----------------------------------------------------------------------------
// raster_to_24pin_band_formatter
// Transposes raster lines into 24-dot bands and emits the printer stream.
// ----------------------------------------------------------------------------
// One word is accepted per clock while full is low and results are popped;
// each word gives exactly one result, which passes the job queue, the store
// stage and the result queue on its way to the result ports. The rate is set
// by the column store: 24 line banks of 512 bytes, each word making at most
// one read-modify-write or one row read-and-clear. After reset full stays
// high while the store is cleared one row per cycle.
module raster_to_24pin_band_formatter import rtbf_pkg::*; #(
  parameter int unsigned LINE_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] req_type_i,
  input  logic [7:0] pixel_byte_i,
  input  logic       last_in_line_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       end_of_burst_o,
  output logic [1:0] status_o
);

  logic    accept, jq_full, jq_empty, take, clearing;
  job_t    job_in, job_head;
  result_t res;

  assign full   = jq_full || clearing;
  assign accept = push && !full;

  rtbf_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .pixel_byte_i   (pixel_byte_i),
    .last_in_line_i (last_in_line_i),
    .job_o          (job_in)
  );

  rtbf_fifo #(.WIDTH($bits(job_t)), .DEPTH(4)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (job_in),
    .full_o  (jq_full),
    .pop_i   (take),
    .data_o  (job_head),
    .empty_o (jq_empty)
  );

  rtbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_valid_i (!jq_empty),
    .job_take_o  (take),
    .clearing_o  (clearing),
    .res_pop_i   (pop),
    .res_o       (res),
    .res_empty_o (empty)
  );

  assign out_byte_o     = res.out_byte;
  assign out_valid_o    = res.out_valid;
  assign end_of_burst_o = res.end_of_burst;
  assign status_o       = res.status;

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 24-pin band formatter. A directed table covers
// idle pulls, unused request codes, refusals while busy, form feeds, blank
// skips over a chunk, pixels past the line end, the store overrun column and
// byte count saturation; random line/band traffic follows. Each word is
// predicted in order and compared field by field with the popped result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import rtbf_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned LINE_LEN = 512;
  localparam int unsigned COLS = 4096;

  typedef enum int {K_ONE, K_PAD, K_LINES, K_DRAIN} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] req;
    logic [7:0] px;
    bit         last;
    int         n;
    bit         chk;
    result_t    want;
  } row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] req_type_i = REQ_RASTER;
  logic [7:0] pixel_byte_i = 8'h00;
  logic       last_in_line_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       end_of_burst_o;
  logic [1:0] status_o;

  raster_to_24pin_band_formatter dut (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .pixel_byte_i, .last_in_line_i,
    .empty, .pop, .out_byte_o, .out_valid_o, .end_of_burst_o, .status_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // formatter shadow state
  logic [23:0] col_mem [COLS];
  int unsigned band_ln, line_pos, extent, blanks, word_idx, dots_left;
  logic [3:0]  phase;
  bit          ff_pend;

  result_t stream_q[$];
  int errors = 0;
  int sent = 0;

  function automatic void clear_cols();
    foreach (col_mem[i]) col_mem[i] = '0;
  endfunction

  function automatic bit start_burst();
    if (extent == 0) begin
      if (blanks < 65535) blanks++;
      return 1'b0;
    end
    word_idx = 0;
    if (blanks != 0) begin
      dots_left = blanks * 24;
      blanks = 0;
      phase = PH_S_ESC;
    end else begin
      phase = PH_G_ESC;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] col_byte(int unsigned idx);
    int unsigned col;
    logic [23:0] w;
    col = idx / 3;
    if (col >= COLS) return 8'h00;
    w = col_mem[col];
    return 8'(w >> (16 - 8 * (idx % 3)));
  endfunction

  function automatic void put_raster(logic [7:0] px, bit lst);
    int unsigned col, off;
    if (line_pos < LINE_LEN) begin
      for (int j = 0; j < 8; j++) begin
        if (px[7-j]) begin
          col = line_pos * 8 + j;
          off = col * 3 + band_ln / 8;
          col_mem[col][23-band_ln] = 1'b1;
          if (off + 1 > extent) extent = off + 1;
        end
      end
    end
    if (lst) begin
      line_pos = 0;
      band_ln++;
      if (band_ln >= 24) begin
        band_ln = 0;
        void'(start_burst());
      end
    end else if (line_pos < 1023) begin
      line_pos++;
    end
  endfunction

  function automatic logic [7:0] next_out(output bit eob);
    logic [7:0] b;
    int unsigned n, ncol;
    b = 8'h00;
    eob = 1'b0;
    ncol = extent / 3 + 1;
    case (phase)
      PH_S_ESC: begin b = CH_ESC; phase = PH_S_3; end
      PH_S_3: begin b = CH_3; phase = PH_S_N; end
      PH_S_N: begin
        n = (dots_left < 255) ? dots_left : 255;
        dots_left -= n;
        b = n[7:0];
        phase = PH_S_CR;
      end
      PH_S_CR: begin b = CH_CR; phase = PH_S_LF; end
      PH_S_LF: begin
        b = CH_LF;
        if (dots_left != 0) phase = PH_S_ESC;
        else if (word_idx != 0) begin
          word_idx = 0;
          if (ff_pend) phase = PH_FF;
          else begin
            phase = PH_IDLE;
            eob = 1'b1;
          end
        end else phase = PH_G_ESC;
      end
      PH_G_ESC: begin b = CH_ESC; phase = PH_G_STAR; end
      PH_G_STAR: begin b = CH_STAR; phase = PH_G_MODE; end
      PH_G_MODE: begin b = CH_MODE; phase = PH_G_NL; end
      PH_G_NL: begin b = ncol[7:0]; phase = PH_G_NH; end
      PH_G_NH: begin b = ncol[15:8]; word_idx = 0; phase = PH_G_DATA; end
      PH_G_DATA: begin
        b = col_byte(word_idx);
        word_idx++;
        if (word_idx >= ncol * 3) begin
          clear_cols();
          extent = 0;
          dots_left = 24;
          phase = PH_S_ESC;
        end
      end
      PH_FF: begin
        b = CH_FF;
        ff_pend = 1'b0;
        word_idx = 0;
        phase = PH_IDLE;
        eob = 1'b1;
      end
      default: phase = PH_IDLE;
    endcase
    return b;
  endfunction

  function automatic result_t predict(logic [1:0] rq, logic [7:0] px, bit lst);
    result_t r;
    bit eob, burst;
    r = '0;
    r.status = ST_OK;
    if (rq == REQ_PULL) begin
      if (phase == PH_IDLE) r.status = ST_NOTHING;
      else begin
        r.out_byte = next_out(eob);
        r.out_valid = 1'b1;
        r.end_of_burst = eob;
      end
    end else if (rq == REQ_UNUSED) begin
      r.status = ST_NOTHING;
    end else if (phase != PH_IDLE) begin
      r.status = ST_REFUSED;
    end else if (rq == REQ_RASTER) begin
      put_raster(px, lst);
    end else begin
      burst = 1'b0;
      if (band_ln != 0) burst = start_burst();
      band_ln = 0;
      line_pos = 0;
      blanks = 0;
      if (burst) ff_pend = 1'b1;
      else phase = PH_FF;
    end
    return r;
  endfunction

  task automatic send(logic [1:0] rq, logic [7:0] px, bit lst, bit chk = 1'b0,
                      result_t want = '0);
    result_t r;
    int gap, sel;
    r = predict(rq, px, lst);
    stream_q.push_back(chk ? want : r);
    sent++;
    req_type_i <= rq;
    pixel_byte_i <= px;
    last_in_line_i <= lst;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    sel = $urandom_range(0, 99);
    gap = (sel < 70) ? 0 : (sel < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (phase != PH_IDLE) send(REQ_PULL, 8'($urandom), 1'($urandom));
  endtask

  // result side stalls
  int stall = 0;
  always @(posedge clk_i) begin
    if (stall > 0) begin
      pop <= 1'b0;
      stall <= stall - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 99) < 20) stall <= $urandom_range(1, 3);
      else if ($urandom_range(0, 199) == 0) stall <= $urandom_range(20, 60);
    end
  end

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && pop && !empty) begin
      if (stream_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: byte %h status %0d", out_byte_o, status_o);
      end else begin
        w = stream_q.pop_front();
        if (out_byte_o !== w.out_byte || out_valid_o !== w.out_valid ||
            end_of_burst_o !== w.end_of_burst || status_o !== w.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp byte %h v %b eob %b st %0d, got byte %h v %b eob %b st %0d",
                     w.out_byte, w.out_valid, w.end_of_burst, w.status,
                     out_byte_o, out_valid_o, end_of_burst_o, status_o);
        end
      end
    end
  end

  row_t tbl [] = '{
    '{K_ONE, REQ_PULL, 8'hFF, 1'b1, 1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_NOTHING}},
    '{K_ONE, REQ_UNUSED, 8'hFF, 1'b1, 1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_NOTHING}},
    '{K_ONE, REQ_FF, 8'h00, 1'b0, 1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_RASTER, 8'hFF, 1'b1, 1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_REFUSED}},
    '{K_ONE, REQ_FF, 8'h00, 1'b0, 1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_REFUSED}},
    '{K_ONE, REQ_PULL, 8'h00, 1'b0, 1, 1'b1, '{CH_FF, 1'b1, 1'b1, ST_OK}},
    '{K_ONE, REQ_PULL, 8'h00, 1'b0, 1, 1'b1, '{8'h00, 1'b0, 1'b0, ST_NOTHING}},
    '{K_ONE, REQ_RASTER, 8'hFF, 1'b0, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_RASTER, 8'h81, 1'b1, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_FF, 8'h00, 1'b0, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_DRAIN, REQ_PULL, 8'h00, 1'b0, 0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_LINES, REQ_RASTER, 8'h00, 1'b1, 12 * 24 + 16, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_PAD, REQ_RASTER, 8'h00, 1'b0, 511, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_RASTER, 8'h01, 1'b1, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_PAD, REQ_RASTER, 8'h00, 1'b0, 512, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_RASTER, 8'hFF, 1'b1, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_PAD, REQ_RASTER, 8'h00, 1'b0, 1030, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_RASTER, 8'hAA, 1'b1, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_LINES, REQ_RASTER, 8'h00, 1'b1, 5, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_DRAIN, REQ_PULL, 8'h00, 1'b0, 0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_LINES, REQ_RASTER, 8'h00, 1'b1, 30, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_ONE, REQ_FF, 8'h00, 1'b0, 1, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}},
    '{K_DRAIN, REQ_PULL, 8'h00, 1'b0, 0, 1'b0, '{8'h00, 1'b0, 1'b0, ST_OK}}
  };

  initial begin
    int len, sel, base;
    bit blank_band;
    clear_cols();
    band_ln = 0; line_pos = 0; extent = 0; blanks = 0;
    word_idx = 0; dots_left = 0; phase = PH_IDLE; ff_pend = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tbl[i]) begin
      case (tbl[i].kind)
        K_ONE: send(tbl[i].req, tbl[i].px, tbl[i].last, tbl[i].chk, tbl[i].want);
        K_PAD: repeat (tbl[i].n) send(REQ_RASTER, 8'h00, 1'b0);
        K_LINES: repeat (tbl[i].n) send(REQ_RASTER, 8'h00, 1'b1);
        K_DRAIN: drain();
      endcase
    end

    base = sent;
    blank_band = 1'b0;
    while (sent - base < 850) begin
      if (phase != PH_IDLE) begin
        sel = $urandom_range(0, 99);
        if (sel < 88) send(REQ_PULL, 8'($urandom), 1'($urandom));
        else if (sel < 94) send(REQ_RASTER, 8'($urandom), 1'($urandom));
        else if (sel < 97) send(REQ_FF, 8'($urandom), 1'($urandom));
        else send(REQ_UNUSED, 8'($urandom), 1'($urandom));
      end else begin
        sel = $urandom_range(0, 99);
        if (band_ln == 0) blank_band = ($urandom_range(0, 99) < 30);
        if (sel < 70) begin
          len = ($urandom_range(0, 79) == 0) ? $urandom_range(9, 520) : $urandom_range(1, 6);
          for (int k = 0; k < len; k++)
            send(REQ_RASTER, (blank_band || $urandom_range(0, 2) == 0 ||
                 (len > 8 && $urandom_range(0, 31) != 0)) ? 8'h00 : 8'($urandom),
                 k == len - 1);
        end else if (sel < 78) send(REQ_FF, 8'($urandom), 1'($urandom));
        else if (sel < 85) send(REQ_PULL, 8'($urandom), 1'($urandom));
        else if (sel < 90) send(REQ_UNUSED, 8'($urandom), 1'($urandom));
        else send(REQ_RASTER, blank_band ? 8'h00 : 8'($urandom), 1'($urandom));
      end
    end

    if (push) push <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
